// ===== rtl/hangul_pair_sound_change_macros.svh =====
// assertion macros for the hangul pair sound change block
// needs clk and rst_n in the scope where a macro is used
`ifndef HANGUL_PAIR_SOUND_CHANGE_MACROS_SVH
`define HANGUL_PAIR_SOUND_CHANGE_MACROS_SVH

// same cycle implication
`define HPSC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hpsc assertion failed");

// next cycle implication
`define HPSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hpsc assertion failed");

`endif

// ===== rtl/hpsc_pkg.sv =====
// package for the hangul pair sound change block
// request and result structs, syllable constants, jamo index codes
`default_nettype none

package hpsc_pkg;

  localparam int unsigned CP_W  = 21;
  localparam int unsigned IDX_W = 5;
  localparam int unsigned OFF_W = 14;
  localparam int unsigned REM_W = 10;

  localparam logic [CP_W-1:0] SYL_BASE = 21'h00AC00;
  localparam logic [CP_W-1:0] SYL_LAST = 21'h00D7A3;

  localparam logic [OFF_W-1:0] INIT_SPAN = 14'd588;
  localparam logic [OFF_W-1:0] MED_SPAN  = 14'd28;

  // reciprocals, exact for offsets up to the last syllable
  localparam logic [OFF_W-1:0] RECIP_INIT       = 14'd14267;
  localparam int unsigned      RECIP_INIT_SHIFT = 23;
  localparam logic [OFF_W-1:0] RECIP_MED        = 14'd9363;
  localparam int unsigned      RECIP_MED_SHIFT  = 18;

  // initial indices
  localparam logic [IDX_W-1:0] INI_G   = 5'd0;
  localparam logic [IDX_W-1:0] INI_GG  = 5'd1;
  localparam logic [IDX_W-1:0] INI_D   = 5'd3;
  localparam logic [IDX_W-1:0] INI_DD  = 5'd4;
  localparam logic [IDX_W-1:0] INI_B   = 5'd7;
  localparam logic [IDX_W-1:0] INI_BB  = 5'd8;
  localparam logic [IDX_W-1:0] INI_S   = 5'd9;
  localparam logic [IDX_W-1:0] INI_SS  = 5'd10;
  localparam logic [IDX_W-1:0] INI_J   = 5'd12;
  localparam logic [IDX_W-1:0] INI_JJ  = 5'd13;
  localparam logic [IDX_W-1:0] INI_CH  = 5'd14;
  localparam logic [IDX_W-1:0] INI_K   = 5'd15;
  localparam logic [IDX_W-1:0] INI_T   = 5'd16;
  localparam logic [IDX_W-1:0] INI_P   = 5'd17;
  localparam logic [IDX_W-1:0] INI_H   = 5'd18;

  // final indices
  localparam logic [IDX_W-1:0] FIN_NONE = 5'd0;
  localparam logic [IDX_W-1:0] FIN_G    = 5'd1;
  localparam logic [IDX_W-1:0] FIN_D    = 5'd7;
  localparam logic [IDX_W-1:0] FIN_B    = 5'd17;
  localparam logic [IDX_W-1:0] FIN_J    = 5'd22;
  localparam logic [IDX_W-1:0] FIN_H    = 5'd27;

  typedef struct packed {
    logic [CP_W-1:0] first_char;
    logic [CP_W-1:0] second_char;
  } pair_in_t;

  typedef struct packed {
    logic [CP_W-1:0] first_out;
    logic [CP_W-1:0] second_out;
  } pair_out_t;

  typedef struct packed {
    logic             is_syl;
    logic [IDX_W-1:0] ini;
    logic [REM_W-1:0] rem;
    logic [IDX_W-1:0] fin;
  } syl_parts_t;

  typedef struct packed {
    logic             clear_fin;
    logic [IDX_W-1:0] ini2;
  } change_t;

endpackage

`default_nettype wire

// ===== rtl/hpsc_split.sv =====
// splits one code point into initial, medial remainder and final
// uses hpsc_pkg
`default_nettype none

module hpsc_split (
  input  wire logic [hpsc_pkg::CP_W-1:0] cp,
  output hpsc_pkg::syl_parts_t           parts
);

  logic [hpsc_pkg::CP_W-1:0]    diff;
  logic [hpsc_pkg::OFF_W-1:0]   off;
  logic [2*hpsc_pkg::OFF_W-1:0] prod_ini;
  logic [2*hpsc_pkg::OFF_W-1:0] prod_med;
  logic [2*hpsc_pkg::OFF_W-1:0] q_ini;
  logic [2*hpsc_pkg::OFF_W-1:0] q_med;
  logic [hpsc_pkg::IDX_W-1:0]   ini;
  logic [hpsc_pkg::OFF_W-1:0]   rem_full;
  logic [hpsc_pkg::OFF_W-1:0]   fin_full;

  assign diff     = cp - hpsc_pkg::SYL_BASE;
  assign off      = diff[hpsc_pkg::OFF_W-1:0];
  assign prod_ini = (2*hpsc_pkg::OFF_W)'(off) * (2*hpsc_pkg::OFF_W)'(hpsc_pkg::RECIP_INIT);
  assign prod_med = (2*hpsc_pkg::OFF_W)'(off) * (2*hpsc_pkg::OFF_W)'(hpsc_pkg::RECIP_MED);
  assign q_ini    = prod_ini >> hpsc_pkg::RECIP_INIT_SHIFT;
  assign q_med    = prod_med >> hpsc_pkg::RECIP_MED_SHIFT;
  assign ini      = q_ini[hpsc_pkg::IDX_W-1:0];
  assign rem_full = off - hpsc_pkg::OFF_W'(ini) * hpsc_pkg::INIT_SPAN;
  assign fin_full = off - q_med[hpsc_pkg::OFF_W-1:0] * hpsc_pkg::MED_SPAN;

  always_comb begin
    parts.is_syl = (cp >= hpsc_pkg::SYL_BASE) && (cp <= hpsc_pkg::SYL_LAST);
    parts.ini    = ini;
    parts.rem    = rem_full[hpsc_pkg::REM_W-1:0];
    parts.fin    = fin_full[hpsc_pkg::IDX_W-1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/hpsc_rules.sv =====
// boundary rules: tensing and aspiration across the syllable boundary
// uses hpsc_pkg
`default_nettype none

module hpsc_rules (
  input  wire logic [hpsc_pkg::IDX_W-1:0] fin1,
  input  wire logic [hpsc_pkg::IDX_W-1:0] ini2,
  output hpsc_pkg::change_t               chg
);

  logic [hpsc_pkg::IDX_W-1:0] tensed;

  always_comb begin
    tensed = ini2;
    if (fin1 inside {hpsc_pkg::FIN_G, hpsc_pkg::FIN_D, hpsc_pkg::FIN_B}) begin
      case (ini2)
        hpsc_pkg::INI_G: tensed = hpsc_pkg::INI_GG;
        hpsc_pkg::INI_D: tensed = hpsc_pkg::INI_DD;
        hpsc_pkg::INI_B: tensed = hpsc_pkg::INI_BB;
        hpsc_pkg::INI_S: tensed = hpsc_pkg::INI_SS;
        hpsc_pkg::INI_J: tensed = hpsc_pkg::INI_JJ;
        default:         tensed = ini2;
      endcase
    end
  end

  always_comb begin
    chg.clear_fin = 1'b0;
    chg.ini2      = tensed;
    if (fin1 == hpsc_pkg::FIN_H) begin
      case (tensed)
        hpsc_pkg::INI_G: begin
          chg.clear_fin = 1'b1;
          chg.ini2      = hpsc_pkg::INI_K;
        end
        hpsc_pkg::INI_D: begin
          chg.clear_fin = 1'b1;
          chg.ini2      = hpsc_pkg::INI_T;
        end
        hpsc_pkg::INI_B: begin
          chg.clear_fin = 1'b1;
          chg.ini2      = hpsc_pkg::INI_P;
        end
        hpsc_pkg::INI_J: begin
          chg.clear_fin = 1'b1;
          chg.ini2      = hpsc_pkg::INI_CH;
        end
        default: chg.ini2 = tensed;
      endcase
    end else if (tensed == hpsc_pkg::INI_H) begin
      case (fin1)
        hpsc_pkg::FIN_G: begin
          chg.clear_fin = 1'b1;
          chg.ini2      = hpsc_pkg::INI_K;
        end
        hpsc_pkg::FIN_D: begin
          chg.clear_fin = 1'b1;
          chg.ini2      = hpsc_pkg::INI_T;
        end
        hpsc_pkg::FIN_B: begin
          chg.clear_fin = 1'b1;
          chg.ini2      = hpsc_pkg::INI_P;
        end
        hpsc_pkg::FIN_J: begin
          chg.clear_fin = 1'b1;
          chg.ini2      = hpsc_pkg::INI_CH;
        end
        default: chg.ini2 = tensed;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hangul_pair_sound_change.sv =====
// throughput: one request per cycle, busy is never raised
// path: request register, split and rules, result register
// reset: rst_n synchronous active low, clears the valid pipeline only
// the receiver cannot stall, each result shows for one cycle
`default_nettype none

module hangul_pair_sound_change (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output      logic               busy,
  input  wire hpsc_pkg::pair_in_t in_data,
  output      logic               out_valid,
  output      hpsc_pkg::pair_out_t out_data
);

  `include "hangul_pair_sound_change_macros.svh"

  logic                 valid_r;
  logic                 out_valid_r;
  hpsc_pkg::pair_in_t   in_r;
  hpsc_pkg::pair_out_t  out_r;
  hpsc_pkg::pair_out_t  out_nxt;
  hpsc_pkg::syl_parts_t parts1;
  hpsc_pkg::syl_parts_t parts2;
  hpsc_pkg::change_t    chg;
  logic                 both_syl;
  logic                 chk_pass;
  logic                 chk_syl;
  logic                 chk_first;
  logic                 res_in_block;

  hpsc_split u_split1 (
    .cp    (in_r.first_char),
    .parts (parts1)
  );

  hpsc_split u_split2 (
    .cp    (in_r.second_char),
    .parts (parts2)
  );

  hpsc_rules u_rules (
    .fin1 (parts1.fin),
    .ini2 (parts2.ini),
    .chg  (chg)
  );

  assign both_syl = parts1.is_syl && parts2.is_syl;

  always_comb begin
    out_nxt.first_out  = in_r.first_char;
    out_nxt.second_out = in_r.second_char;
    if (both_syl) begin
      if (chg.clear_fin) begin
        out_nxt.first_out = in_r.first_char - hpsc_pkg::CP_W'(parts1.fin);
      end
      out_nxt.second_out = hpsc_pkg::SYL_BASE
                         + hpsc_pkg::CP_W'(chg.ini2) * hpsc_pkg::CP_W'(hpsc_pkg::INIT_SPAN)
                         + hpsc_pkg::CP_W'(parts2.rem);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= start;
      out_valid_r <= valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      in_r <= in_data;
    end
    if (valid_r) begin
      out_r <= out_nxt;
    end
  end

  assign busy      = 1'b0;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign chk_pass     = valid_r && !both_syl;
  assign chk_syl      = valid_r && both_syl;
  assign chk_first    = valid_r && both_syl && !chg.clear_fin;
  assign res_in_block = (out_data.first_out >= hpsc_pkg::SYL_BASE)
                     && (out_data.first_out <= hpsc_pkg::SYL_LAST)
                     && (out_data.second_out >= hpsc_pkg::SYL_BASE)
                     && (out_data.second_out <= hpsc_pkg::SYL_LAST);

  `HPSC_ASSERT_NOW(a_valid_follows_request, out_valid, $past(start, 2))
  `HPSC_ASSERT_NEXT(a_passthrough, chk_pass, out_data == $past(in_r))
  `HPSC_ASSERT_NEXT(a_stays_syllable, chk_syl, res_in_block)
  `HPSC_ASSERT_NEXT(a_first_kept, chk_first, out_data.first_out == $past(in_r.first_char))

endmodule

`default_nettype wire

// ===== test/tb_hangul_pair_sound_change.sv =====
// testbench for hangul_pair_sound_change: directed and random code point pairs,
// expected pairs predicted in the bench and checked field by field against the results
// depends on hpsc_pkg and the hangul_pair_sound_change rtl
`default_nettype none

module tb_hangul_pair_sound_change;
  timeunit 1ns;
  timeprecision 1ps;

  import hpsc_pkg::*;

  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned ITEMS_PER_PHASE  = 225;
  localparam int unsigned NUM_PHASES       = 4;
  localparam int unsigned DRAIN_CYCLES     = 10;

  logic      clk;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  logic      busy;
  pair_in_t  in_data = '0;
  logic      out_valid;
  pair_out_t out_data;

  pair_in_t  pending_pairs[$];
  pair_out_t expected_pairs[$];

  int unsigned sender_idle_pct = 0;
  int unsigned accepted_count  = 0;
  int unsigned changed_count   = 0;
  int unsigned checked_count   = 0;
  int unsigned error_count     = 0;
  int unsigned cycle_count     = 0;

  hangul_pair_sound_change uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [CP_W-1:0] compose_syllable(int unsigned ini, int unsigned med,
                                                       int unsigned fin);
    return SYL_BASE + CP_W'(ini) * CP_W'(INIT_SPAN) + CP_W'(med) * CP_W'(MED_SPAN)
           + CP_W'(fin);
  endfunction

  function automatic pair_out_t apply_boundary_rules(pair_in_t req);
    pair_out_t        res;
    logic [OFF_W-1:0] off1;
    logic [OFF_W-1:0] off2;
    logic [IDX_W-1:0] ini1, med1, fin1, ini2, med2, fin2;
    res.first_out  = req.first_char;
    res.second_out = req.second_char;
    if (req.first_char >= SYL_BASE && req.first_char <= SYL_LAST &&
        req.second_char >= SYL_BASE && req.second_char <= SYL_LAST) begin
      off1 = OFF_W'(req.first_char - SYL_BASE);
      off2 = OFF_W'(req.second_char - SYL_BASE);
      ini1 = IDX_W'(off1 / INIT_SPAN);
      med1 = IDX_W'((off1 % INIT_SPAN) / MED_SPAN);
      fin1 = IDX_W'(off1 % MED_SPAN);
      ini2 = IDX_W'(off2 / INIT_SPAN);
      med2 = IDX_W'((off2 % INIT_SPAN) / MED_SPAN);
      fin2 = IDX_W'(off2 % MED_SPAN);
      // tensing after a stop final
      case (fin1)
        FIN_G, FIN_D, FIN_B: begin
          case (ini2)
            INI_G: ini2 = INI_GG;
            INI_D: ini2 = INI_DD;
            INI_B: ini2 = INI_BB;
            INI_S: ini2 = INI_SS;
            INI_J: ini2 = INI_JJ;
            default: ;
          endcase
        end
        default: ;
      endcase
      if (fin1 == FIN_H) begin
        case (ini2)
          INI_G: begin ini2 = INI_K; fin1 = FIN_NONE; end
          INI_D: begin ini2 = INI_T; fin1 = FIN_NONE; end
          INI_B: begin ini2 = INI_P; fin1 = FIN_NONE; end
          INI_J: begin ini2 = INI_CH; fin1 = FIN_NONE; end
          default: ;
        endcase
      end else if (ini2 == INI_H) begin
        case (fin1)
          FIN_G: begin ini2 = INI_K; fin1 = FIN_NONE; end
          FIN_D: begin ini2 = INI_T; fin1 = FIN_NONE; end
          FIN_B: begin ini2 = INI_P; fin1 = FIN_NONE; end
          FIN_J: begin ini2 = INI_CH; fin1 = FIN_NONE; end
          default: ;
        endcase
      end
      res.first_out  = compose_syllable(ini1, med1, fin1);
      res.second_out = compose_syllable(ini2, med2, fin2);
    end
    return res;
  endfunction

  function automatic pair_in_t random_pair();
    pair_in_t    req;
    int unsigned kind;
    int unsigned fin1;
    int unsigned ini2;
    kind = $urandom_range(99);
    if (kind < 55) begin
      // syllable pairs aimed at the boundary rules
      fin1 = $urandom_range(27);
      ini2 = $urandom_range(18);
      if ($urandom_range(1)) begin
        case ($urandom_range(4))
          0: fin1 = FIN_G;
          1: fin1 = FIN_D;
          2: fin1 = FIN_B;
          3: fin1 = FIN_J;
          default: fin1 = FIN_H;
        endcase
      end
      if ($urandom_range(1)) begin
        case ($urandom_range(5))
          0: ini2 = INI_G;
          1: ini2 = INI_D;
          2: ini2 = INI_B;
          3: ini2 = INI_S;
          4: ini2 = INI_J;
          default: ini2 = INI_H;
        endcase
      end
      req.first_char  = compose_syllable($urandom_range(18), $urandom_range(20), fin1);
      req.second_char = compose_syllable(ini2, $urandom_range(20), $urandom_range(27));
    end else if (kind < 70) begin
      req.first_char  = SYL_BASE + CP_W'($urandom_range(11171));
      req.second_char = SYL_BASE + CP_W'($urandom_range(11171));
    end else if (kind < 80) begin
      case ($urandom_range(3))
        0: req.first_char = SYL_BASE - CP_W'(1);
        1: req.first_char = SYL_BASE;
        2: req.first_char = SYL_LAST;
        default: req.first_char = SYL_LAST + CP_W'(1);
      endcase
      case ($urandom_range(3))
        0: req.second_char = SYL_BASE - CP_W'(1);
        1: req.second_char = SYL_BASE;
        2: req.second_char = SYL_LAST;
        default: req.second_char = SYL_LAST + CP_W'(1);
      endcase
    end else if (kind < 90) begin
      req.first_char  = SYL_BASE + CP_W'($urandom_range(11171));
      req.second_char = CP_W'($urandom);
      if ($urandom_range(1)) begin
        req = {req.second_char, req.first_char};
      end
    end else begin
      req.first_char  = CP_W'($urandom);
      req.second_char = CP_W'($urandom);
    end
    return req;
  endfunction

  task automatic queue_pair(logic [CP_W-1:0] first_cp, logic [CP_W-1:0] second_cp);
    pair_in_t req;
    req.first_char  = first_cp;
    req.second_char = second_cp;
    pending_pairs.push_back(req);
  endtask

  task automatic report_mismatch(string what, logic [CP_W-1:0] got, logic [CP_W-1:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    error_count++;
  endtask

  // request driver
  always @(posedge clk) begin
    pair_out_t predicted;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predicted = apply_boundary_rules(in_data);
        expected_pairs.push_back(predicted);
        if (predicted != {in_data.first_char, in_data.second_char}) changed_count++;
        void'(pending_pairs.pop_front());
        accepted_count++;
      end
      if (pending_pairs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        start   <= 1'b1;
        in_data <= pending_pairs[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    pair_out_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_pairs.size() == 0) begin
        report_mismatch("result with no request pending", out_data.first_out, '0);
      end else begin
        want = expected_pairs.pop_front();
        checked_count++;
        if (out_data.first_out !== want.first_out)
          report_mismatch("first_out", out_data.first_out, want.first_out);
        if (out_data.second_out !== want.second_out)
          report_mismatch("second_out", out_data.second_out, want.second_out);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    queue_pair(SYL_BASE, SYL_BASE);
    queue_pair(SYL_LAST, SYL_LAST);
    queue_pair(SYL_BASE - CP_W'(1), SYL_BASE);
    queue_pair(SYL_LAST, SYL_LAST + CP_W'(1));
    queue_pair('0, 21'h1FFFFF);
    queue_pair(21'h10FFFF, SYL_BASE);
    queue_pair(21'h1FAC00, compose_syllable(0, 0, 0));
    queue_pair(compose_syllable(5, 3, FIN_G), compose_syllable(INI_G, 2, 4));
    queue_pair(compose_syllable(2, 8, FIN_D), compose_syllable(INI_D, 0, 0));
    queue_pair(compose_syllable(11, 1, FIN_B), compose_syllable(INI_B, 20, 27));
    queue_pair(compose_syllable(0, 0, FIN_G), compose_syllable(INI_S, 5, 1));
    queue_pair(compose_syllable(18, 20, FIN_D), compose_syllable(INI_J, 9, 3));
    queue_pair(compose_syllable(7, 4, FIN_B), compose_syllable(2, 4, 7));
    queue_pair(compose_syllable(3, 6, FIN_H), compose_syllable(INI_G, 1, 2));
    queue_pair(compose_syllable(4, 7, FIN_H), compose_syllable(INI_D, 3, 0));
    queue_pair(compose_syllable(9, 2, FIN_H), compose_syllable(INI_B, 12, 8));
    queue_pair(compose_syllable(1, 0, FIN_H), compose_syllable(INI_J, 20, 27));
    queue_pair(compose_syllable(6, 9, FIN_H), compose_syllable(INI_H, 0, 0));
    queue_pair(compose_syllable(6, 9, FIN_H), compose_syllable(INI_S, 2, 2));
    queue_pair(compose_syllable(10, 1, FIN_G), compose_syllable(INI_H, 0, 4));
    queue_pair(compose_syllable(12, 5, FIN_D), compose_syllable(INI_H, 8, 0));
    queue_pair(compose_syllable(14, 11, FIN_B), compose_syllable(INI_H, 13, 21));
    queue_pair(compose_syllable(16, 19, FIN_J), compose_syllable(INI_H, 20, 27));
    queue_pair(compose_syllable(8, 2, 4), compose_syllable(INI_H, 1, 1));
    queue_pair(compose_syllable(18, 20, 27), compose_syllable(18, 20, 27));

    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: sender_idle_pct = 0;
        1: sender_idle_pct = 66;
        2: sender_idle_pct = 0;
        default: sender_idle_pct = 13;
      endcase
      for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++) pending_pairs.push_back(random_pair());
      while (pending_pairs.size() != 0 || expected_pairs.size() != 0) @(negedge clk);
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("%0d pairs sent over %0d idle phases, %0d results checked, %0d altered by rules",
             accepted_count, NUM_PHASES, checked_count, changed_count);
    if (error_count == 0 && expected_pairs.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d results missing", error_count, expected_pairs.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/hpsc_pkg.sv
rtl/hpsc_split.sv
rtl/hpsc_rules.sv
rtl/hangul_pair_sound_change.sv
test/tb_hangul_pair_sound_change.sv
